// File: hdl/bpb_pkg.sv
// ----------------------------------------------------------------------------
// bpb_pkg
// Shared types and constants of the bitmap pixel binariser: depth mode and
// register index codes, field widths and the pixel job passed through the
// queue.
// ----------------------------------------------------------------------------
package bpb_pkg;

   localparam int CFG_W   = 13;
   localparam int COORD_W = 12;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [1:0] MODE_1BPP  = 2'd0;
   localparam logic [1:0] MODE_4BPP  = 2'd1;
   localparam logic [1:0] MODE_8BPP  = 2'd2;
   localparam logic [1:0] MODE_24BPP = 2'd3;

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DEPTH_MODE   = 2'd2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1;
   localparam logic [1:0]       MODE_RESET   = MODE_8BPP;

   localparam logic [BYTE_W-1:0] HI_NIBBLE = 8'hf0;
   localparam logic [BYTE_W-1:0] LO_NIBBLE = 8'h0f;
   localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hff;

   typedef struct packed {
      logic [BYTE_W-1:0] on;
      logic [CNT_W-1:0]  count;
   } pix_job_type;

   typedef struct packed {
      logic finished;
   } front_status_type;

endpackage

// File: hdl/bpb_front.sv
// ----------------------------------------------------------------------------
// bpb_front
// Byte decoder: tracks row byte position, row number and held colour bytes,
// and turns each accepted byte into a pixel job for the queue.
// ----------------------------------------------------------------------------
module bpb_front #(
   parameter int WW    = 13,
   parameter int HW    = 13,
   parameter int POS_W = 15,
   parameter int COL_W = 18
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     restart,
   input  logic [WW-1:0]            eff_w,
   input  logic [HW-1:0]            eff_h,
   input  logic [1:0]               mode,
   input  logic                     accept,
   input  logic [bpb_pkg::BYTE_W-1:0] data_byte,
   output logic                     q_push,
   output bpb_pkg::pix_job_type     q_job,
   output logic [COL_W-1:0]         q_col,
   output logic [HW-1:0]            q_row,
   output bpb_pkg::front_status_type status
);

   localparam int BPR_W = POS_W + 1;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  col24_ff, col24_in;
   logic [1:0]        phase_ff, phase_in;
   logic [HW-1:0]     row_ff, row_in;
   logic [15:0]       held_ff, held_in;
   logic              fin_ff, fin_in;

   logic [BPR_W-1:0]  wx, bpr, pos_next;
   logic [COL_W-1:0]  base, rem, cap;
   logic              in_range, gen;
   logic [bpb_pkg::CNT_W-1:0]  count;
   logic [bpb_pkg::BYTE_W-1:0] on;
   logic              work;

   assign wx       = BPR_W'(eff_w);
   assign pos_next = BPR_W'(pos_ff) + BPR_W'(1);
   assign work     = accept && !fin_ff;

   always_comb begin
      unique case (mode)
         bpb_pkg::MODE_1BPP:  bpr = ((wx + BPR_W'(31)) >> 5) << 2;
         bpb_pkg::MODE_4BPP:  bpr = ((wx + BPR_W'(3)) >> 2) << 1;
         bpb_pkg::MODE_8BPP:  bpr = (wx + BPR_W'(3)) & ~BPR_W'(3);
         default:             bpr = (wx + (wx << 1) + BPR_W'(3)) & ~BPR_W'(3);
      endcase
   end

   always_comb begin
      on = '0;
      unique case (mode)
         bpb_pkg::MODE_1BPP: begin
            base = {pos_ff, 3'b000};
            cap  = COL_W'(8);
            gen  = 1'b1;
            for (int i = 0; i < bpb_pkg::BYTE_W; i++) begin
               on[i] = data_byte[bpb_pkg::BYTE_W-1-i];
            end
         end
         bpb_pkg::MODE_4BPP: begin
            base  = COL_W'({pos_ff, 1'b0});
            cap   = COL_W'(2);
            gen   = 1'b1;
            on[0] = (data_byte & bpb_pkg::HI_NIBBLE) == bpb_pkg::HI_NIBBLE;
            on[1] = (data_byte & bpb_pkg::LO_NIBBLE) == bpb_pkg::LO_NIBBLE;
         end
         bpb_pkg::MODE_8BPP: begin
            base  = COL_W'(pos_ff);
            cap   = COL_W'(1);
            gen   = 1'b1;
            on[0] = data_byte == bpb_pkg::FULL_BYTE;
         end
         default: begin
            base  = COL_W'(col24_ff);
            cap   = COL_W'(1);
            gen   = phase_ff == 2'd2;
            on[0] = (held_ff == 16'hffff) && (data_byte == bpb_pkg::FULL_BYTE);
         end
      endcase
   end

   assign in_range = base < COL_W'(eff_w);
   assign rem      = COL_W'(eff_w) - base;

   always_comb begin
      if (!gen || !in_range) begin
         count = '0;
      end else if (rem > cap) begin
         count = bpb_pkg::CNT_W'(cap);
      end else begin
         count = bpb_pkg::CNT_W'(rem);
      end
   end

   assign q_push          = work && (count != '0);
   assign q_job.on        = on;
   assign q_job.count     = count;
   assign q_col           = base;
   assign q_row           = row_ff;
   assign status.finished = fin_ff;

   always_comb begin
      pos_in   = pos_ff;
      col24_in = col24_ff;
      phase_in = phase_ff;
      row_in   = row_ff;
      held_in  = held_ff;
      fin_in   = fin_ff;
      if (work) begin
         if (mode == bpb_pkg::MODE_24BPP) begin
            if (phase_ff == 2'd0) begin
               held_in[7:0] = data_byte;
            end else if (phase_ff == 2'd1) begin
               held_in[15:8] = data_byte;
            end
         end
         if (pos_next >= bpr) begin
            pos_in   = '0;
            col24_in = '0;
            phase_in = 2'd0;
            row_in   = row_ff + HW'(1);
            fin_in   = (row_ff + HW'(1)) >= eff_h;
         end else begin
            pos_in = pos_next[POS_W-1:0];
            if (phase_ff == 2'd2) begin
               phase_in = 2'd0;
               col24_in = col24_ff + POS_W'(1);
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pos_ff   <= '0;
         col24_ff <= '0;
         phase_ff <= 2'd0;
         row_ff   <= '0;
         held_ff  <= '0;
         fin_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         col24_ff <= col24_in;
         phase_ff <= phase_in;
         row_ff   <= row_in;
         held_ff  <= held_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

// File: hdl/bpb_queue.sv
// ----------------------------------------------------------------------------
// bpb_queue
// Short first-in first-out queue of pixel jobs between decoder and
// serialiser.
// ----------------------------------------------------------------------------
module bpb_queue #(
   parameter int DATA_W = 42
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   input  logic              pop,
   output logic [DATA_W-1:0] rdata,
   output logic              full,
   output logic              empty
);

   logic [DATA_W-1:0]              mem_ff [bpb_pkg::QUEUE_DEPTH];
   logic [bpb_pkg::QPTR_W-1:0]     wptr_ff, wptr_in;
   logic [bpb_pkg::QPTR_W-1:0]     rptr_ff, rptr_in;
   logic [bpb_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                           do_push, do_pop;

   assign full    = cnt_ff == bpb_pkg::QCNT_W'(bpb_pkg::QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = do_push ? wptr_ff + bpb_pkg::QPTR_W'(1) : wptr_ff;
      rptr_in = do_pop  ? rptr_ff + bpb_pkg::QPTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + bpb_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - bpb_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: hdl/bpb_back.sv
// ----------------------------------------------------------------------------
// bpb_back
// Pixel serialiser: takes pixel jobs from the queue and sends one pixel per
// cycle into the result register whenever it is free, with column, row and end flags.
// ----------------------------------------------------------------------------
module bpb_back #(
   parameter int WW    = 13,
   parameter int HW    = 13,
   parameter int COL_W = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WW-1:0]        eff_w,
   input  logic [HW-1:0]        eff_h,
   input  logic                 q_empty,
   input  bpb_pkg::pix_job_type q_job,
   input  logic [COL_W-1:0]     q_col,
   input  logic [HW-1:0]        q_row,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 rsp_pixel_on,
   output logic [bpb_pkg::COORD_W-1:0] rsp_pixel_column,
   output logic [bpb_pkg::COORD_W-1:0] rsp_pixel_row,
   output logic                 rsp_last_of_byte,
   output logic                 rsp_row_end,
   output logic                 rsp_image_end
);

   logic                 cur_valid_ff, cur_valid_in;
   bpb_pkg::pix_job_type cur_job_ff;
   logic [COL_W-1:0]     cur_col_ff;
   logic [HW-1:0]        cur_row_ff;
   logic [2:0]           idx_ff, idx_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 on_ff;
   logic [COL_W-1:0]     col_ff;
   logic [HW-1:0]        row_ff;
   logic                 lob_ff, rend_ff, iend_ff;

   logic                 out_free, emit, last, load, rend;
   logic [COL_W-1:0]     col;

   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = cur_valid_ff && out_free;
   assign last     = ({1'b0, idx_ff} + bpb_pkg::CNT_W'(1)) == cur_job_ff.count;
   assign load     = !q_empty && (!cur_valid_ff || (emit && last));
   assign q_pop    = load;

   assign col  = cur_col_ff + COL_W'(idx_ff);
   assign rend = (col + COL_W'(1)) == COL_W'(eff_w);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_valid_in = 1'b1;
         idx_in       = 3'd0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
         if (last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_job_ff <= q_job;
         cur_col_ff <= q_col;
         cur_row_ff <= q_row;
      end
      if (emit) begin
         on_ff   <= cur_job_ff.on[idx_ff];
         col_ff  <= col;
         row_ff  <= cur_row_ff;
         lob_ff  <= last;
         rend_ff <= rend;
         iend_ff <= rend && ((cur_row_ff + HW'(1)) == eff_h);
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_pixel_on     = on_ff;
   assign rsp_pixel_column = bpb_pkg::COORD_W'(col_ff);
   assign rsp_pixel_row    = bpb_pkg::COORD_W'(row_ff);
   assign rsp_last_of_byte = lob_ff;
   assign rsp_row_end      = rend_ff;
   assign rsp_image_end    = iend_ff;

endmodule

// File: hdl/bitmap_pixel_binarizer_core.sv
// ----------------------------------------------------------------------------
// bitmap_pixel_binarizer_core
// Decodes bitmap pixel-array bytes at 1, 4, 8 or 24 bits per pixel into one
// binary pixel per image column, skipping row padding and trailing bytes.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while req_full is low; the decoder turns each
// byte into a pixel job that waits in a four-entry queue, and the serialiser
// behind it gives one pixel per cycle into a result register while that
// register is free or being popped. A byte yields up to 8 pixels at 1 bpp, 2 at
// 4 bpp, 1 at 8 bpp, and a 24 bpp colour gives one pixel per three bytes;
// bytes that yield nothing (padding, first two colour bytes, data after the
// image) queue no job. A pixel passes from the queue through the current-job
// register into the result register. Any write to a listed register restarts
// the stream; writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module bitmap_pixel_binarizer_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [bpb_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [bpb_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_pixel_on,
   output logic [bpb_pkg::COORD_W-1:0]   rsp_pixel_column,
   output logic [bpb_pkg::COORD_W-1:0]   rsp_pixel_row,
   output logic                          rsp_last_of_byte,
   output logic                          rsp_row_end,
   output logic                          rsp_image_end
);

   localparam int CFG_MAX = (1 << bpb_pkg::CFG_W) - 1;
   localparam int WMAX    = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
   localparam int HMAX    = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
   localparam int WW      = $clog2(WMAX + 1);
   localparam int HW      = $clog2(HMAX + 1);
   localparam int POS_W   = $clog2(3 * WMAX + 4);
   localparam int COL_W   = POS_W + 3;
   localparam int JOB_W   = $bits(bpb_pkg::pix_job_type);
   localparam int Q_W     = JOB_W + COL_W + HW;

   logic [bpb_pkg::CFG_W-1:0] width_ff, height_ff;
   logic [1:0]                mode_ff;
   logic                      restart;
   logic [WW-1:0]             eff_w;
   logic [HW-1:0]             eff_h;

   logic                      q_push, q_pop, q_full, q_empty;
   bpb_pkg::pix_job_type      q_wjob, q_rjob;
   logic [COL_W-1:0]          q_wcol, q_rcol;
   logic [HW-1:0]             q_wrow, q_rrow;
   bpb_pkg::front_status_type front_status;

   always_comb begin
      unique case (csr_index)
         bpb_pkg::CSR_IMAGE_WIDTH,
         bpb_pkg::CSR_IMAGE_HEIGHT,
         bpb_pkg::CSR_DEPTH_MODE: restart = csr_we;
         default:                 restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bpb_pkg::WIDTH_RESET;
         height_ff <= bpb_pkg::HEIGHT_RESET;
         mode_ff   <= bpb_pkg::MODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bpb_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            bpb_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            bpb_pkg::CSR_DEPTH_MODE:   mode_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // zero reads as one, oversize saturates
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WW'(1);
      end else if (width_ff > bpb_pkg::CFG_W'(WMAX)) begin
         eff_w = WW'(WMAX);
      end else begin
         eff_w = width_ff[WW-1:0];
      end
      if (height_ff == '0) begin
         eff_h = HW'(1);
      end else if (height_ff > bpb_pkg::CFG_W'(HMAX)) begin
         eff_h = HW'(HMAX);
      end else begin
         eff_h = height_ff[HW-1:0];
      end
   end

   assign req_full = q_full;

   bpb_front #(
      .WW    (WW),
      .HW    (HW),
      .POS_W (POS_W),
      .COL_W (COL_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .eff_w     (eff_w),
      .eff_h     (eff_h),
      .mode      (mode_ff),
      .accept    (req_push && !q_full),
      .data_byte (req_data_byte),
      .q_push    (q_push),
      .q_job     (q_wjob),
      .q_col     (q_wcol),
      .q_row     (q_wrow),
      .status    (front_status)
   );

   bpb_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata ({q_wjob, q_wcol, q_wrow}),
      .pop   (q_pop),
      .rdata ({q_rjob, q_rcol, q_rrow}),
      .full  (q_full),
      .empty (q_empty)
   );

   bpb_back #(
      .WW    (WW),
      .HW    (HW),
      .COL_W (COL_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .eff_w            (eff_w),
      .eff_h            (eff_h),
      .q_empty          (q_empty),
      .q_job            (q_rjob),
      .q_col            (q_rcol),
      .q_row            (q_rrow),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_on     (rsp_pixel_on),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_last_of_byte (rsp_last_of_byte),
      .rsp_row_end      (rsp_row_end),
      .rsp_image_end    (rsp_image_end)
   );

`ifndef ASSERT_OFF
   a_job_count: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_wjob.count != '0) && (q_wjob.count <= bpb_pkg::CNT_W'(8)))
      else $error("pixel job with bad count");

   a_no_job_after_image: assert property (@(posedge clock) disable iff (reset)
      front_status.finished |-> !q_push)
      else $error("pixel job after image end");

   a_image_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_image_end) |-> rsp_row_end)
      else $error("image end without row end");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present after reset");
`endif

endmodule
